/* rtl/cav_pkg.sv */
// ----------------------------------------------------------------------------
// cav_pkg
// Shared types and constants for the cavity local-maximum marker.
// ----------------------------------------------------------------------------
`default_nettype none

package cav_pkg;

    localparam int PIXEL_W      = 8;
    localparam int SIDE_W       = 11;
    localparam logic [PIXEL_W-1:0] CAVITY_MARK = 8'h58;  // ASCII 'X'

    // Output queue: room for a full pair of results plus slack for streaming
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

    typedef logic [PIXEL_W-1:0] pixel_t;

    // One line store entry: the row two back and the row just above
    typedef struct packed {
        pixel_t far_px;
        pixel_t near_px;
    } line_entry_t;

    typedef struct packed {
        logic   frame_end;
        pixel_t pixel;
    } result_t;

    // Up to two results pushed per item; res[0] goes out first
    typedef struct packed {
        logic [1:0]       cnt;
        result_t [1:0]    res;
    } push_t;

endpackage

`default_nettype wire

/* rtl/cav_line_mem.sv */
// ----------------------------------------------------------------------------
// cav_line_mem
// Two-row line store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module cav_line_mem #(
    parameter int AW    = 10,
    parameter int DEPTH = 1024
) (
    input  wire                       aclk,
    input  wire                       wr_en,
    input  wire [AW-1:0]              wr_addr,
    input  wire cav_pkg::line_entry_t wr_data,
    input  wire                       rd_en,
    input  wire [AW-1:0]              rd_addr_a,
    input  wire [AW-1:0]              rd_addr_b,
    output cav_pkg::line_entry_t      rd_data_a,
    output cav_pkg::line_entry_t      rd_data_b
);

    cav_pkg::line_entry_t mem [DEPTH];
    cav_pkg::line_entry_t rd_a_reg;
    cav_pkg::line_entry_t rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read returns the contents before a same-edge write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

/* rtl/cav_out_fifo.sv */
// ----------------------------------------------------------------------------
// cav_out_fifo
// Small result queue taking up to two results per cycle, one out per cycle while m_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module cav_out_fifo (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire cav_pkg::push_t   push,
    output logic                  space_ok,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output cav_pkg::result_t      m_result
);

    cav_pkg::result_t                fifo_reg [cav_pkg::OUT_DEPTH];
    logic [cav_pkg::OUT_PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [cav_pkg::OUT_PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [cav_pkg::OUT_CW-1:0]      count_reg,  count_next;
    logic [cav_pkg::OUT_PW-1:0]      wr_ptr_plus1;
    logic                            pop;

    assign pop          = m_tvalid && m_tready;
    assign wr_ptr_plus1 = wr_ptr_reg + cav_pkg::OUT_PW'(1);
    assign space_ok     = (count_reg <= cav_pkg::OUT_CW'(cav_pkg::OUT_DEPTH - 2));
    assign m_tvalid     = (count_reg != '0);
    assign m_result     = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + cav_pkg::OUT_PW'(push.cnt);
        rd_ptr_next = rd_ptr_reg + cav_pkg::OUT_PW'(pop);
        count_next  = count_reg + cav_pkg::OUT_CW'(push.cnt) - cav_pkg::OUT_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= push.res[0];
        end
        if (push.cnt == 2'd2) begin
            fifo_reg[wr_ptr_plus1] <= push.res[1];
        end
    end

endmodule

`default_nettype wire

/* rtl/cavity_local_max_marker_core.sv */
// ----------------------------------------------------------------------------
// cavity_local_max_marker_core
// Marks 4-neighbor strict local maxima of a square byte grid with 'X'.
// ----------------------------------------------------------------------------
// The first result of an item passes the decision stage, then the output queue.
// Throughput: one pixel per clock while the output queue has room; last-row
//   pixels make two results each, and the single result port throttles input.
// Per pixel one read-modify-write of the line store entry for its column.
// Reset: counters, side (4, clamped to MAX_SIDE) and queue clear at once;
//   line store contents are undefined until written, no clearing pass.
`default_nettype none

module cavity_local_max_marker_core #(
    parameter int MAX_SIDE = 1024
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [10:0] cfg_wr_data,   // side_length
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,       // [7:0] pixel_in
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,       // [7:0] pixel_out
    output logic        m_tlast        // frame_end
);

    localparam int AW = $clog2(MAX_SIDE);

    function automatic logic [AW-1:0] last_index(input logic [cav_pkg::SIDE_W-1:0] v);
        logic [AW-1:0] idx;
        if (v == '0) begin
            idx = '0;
        end else if (int'(v) > MAX_SIDE) begin
            idx = AW'(MAX_SIDE - 1);
        end else begin
            idx = AW'(int'(v) - 1);
        end
        return idx;
    endfunction

    localparam logic [AW-1:0] RESET_LAST = last_index(cav_pkg::SIDE_W'(4));

    // Position of the next pixel to accept
    logic [AW-1:0]          last_idx_reg;
    logic [AW-1:0]          col_reg, col_next;
    logic [AW-1:0]          row_reg, row_next;
    logic                   last_col, last_row;
    logic                   accept;

    // Decision stage
    logic                   s1_valid_reg;
    cav_pkg::pixel_t        s1_px_reg;
    logic [AW-1:0]          s1_col_reg;
    logic                   s1_row_ge1_reg, s1_row_ge2_reg, s1_col_ge1_reg;
    logic                   s1_last_col_reg, s1_last_row_reg;
    logic                   s1_fire;
    cav_pkg::pixel_t        left_reg;

    // Line store and forwarding
    logic [AW-1:0]          rd_addr_a, rd_addr_b;
    cav_pkg::line_entry_t   rd_data_a, rd_data_b;
    cav_pkg::line_entry_t   wr_data;
    cav_pkg::line_entry_t   fwd_data_reg;
    logic                   fwd_a_reg, fwd_b_reg;
    cav_pkg::line_entry_t   entry_a, entry_b;

    cav_pkg::pixel_t        mid, above, right;
    logic                   cavity;
    cav_pkg::result_t       res_up, res_self;
    cav_pkg::push_t         push;
    logic                   space_ok;
    cav_pkg::result_t       m_result;

    assign accept   = s_tvalid && s_tready;
    assign s1_fire  = s1_valid_reg && space_ok;
    assign s_tready = !s1_valid_reg || s1_fire;

    assign last_col = (col_reg == last_idx_reg);
    assign last_row = (row_reg == last_idx_reg);

    always_comb begin
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + AW'(1);
        end else begin
            col_next = col_reg + AW'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_idx_reg <= RESET_LAST;
            col_reg      <= '0;
            row_reg      <= '0;
            left_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                last_idx_reg <= last_index(cfg_wr_data);
                col_reg      <= '0;
                row_reg      <= '0;
                left_reg     <= '0;
            end else begin
                if (accept) begin
                    col_reg <= col_next;
                    row_reg <= row_next;
                end
                if (s1_fire) begin
                    left_reg <= mid;
                end
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Read this column and the next; forward the entry written on the same edge
    assign rd_addr_a = col_reg;
    assign rd_addr_b = col_reg + AW'(1);

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_px_reg       <= s_tdata;
            s1_col_reg      <= col_reg;
            s1_row_ge1_reg  <= (row_reg != '0);
            s1_row_ge2_reg  <= (row_reg > AW'(1));
            s1_col_ge1_reg  <= (col_reg != '0);
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
            fwd_a_reg       <= s1_fire && (s1_col_reg == rd_addr_a);
            fwd_b_reg       <= s1_fire && (s1_col_reg == rd_addr_b);
            fwd_data_reg    <= wr_data;
        end
    end

    cav_line_mem #(
        .AW    (AW),
        .DEPTH (MAX_SIDE)
    ) u_line_mem (
        .aclk      (aclk),
        .wr_en     (s1_fire),
        .wr_addr   (s1_col_reg),
        .wr_data   (wr_data),
        .rd_en     (accept),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign entry_a = fwd_a_reg ? fwd_data_reg : rd_data_a;
    assign entry_b = fwd_b_reg ? fwd_data_reg : rd_data_b;

    assign mid   = entry_a.near_px;
    assign above = entry_a.far_px;
    assign right = entry_b.near_px;

    // Shift the column down one row in the store
    assign wr_data = '{far_px: mid, near_px: s1_px_reg};

    assign cavity = s1_row_ge2_reg && s1_col_ge1_reg && !s1_last_col_reg
                    && (mid > above) && (mid > s1_px_reg)
                    && (mid > left_reg) && (mid > right);

    assign res_up   = '{frame_end: 1'b0, pixel: cavity ? cav_pkg::CAVITY_MARK : mid};
    assign res_self = '{frame_end: s1_last_col_reg, pixel: s1_px_reg};

    always_comb begin
        push.cnt = 2'd0;
        push.res = {res_self, res_up};
        if (s1_fire) begin
            priority if (s1_row_ge1_reg && s1_last_row_reg) begin
                push.cnt = 2'd2;
            end else if (s1_row_ge1_reg) begin
                push.cnt = 2'd1;
            end else if (s1_last_row_reg) begin
                push.cnt = 2'd1;
                push.res = {res_self, res_self};
            end else begin
                push.cnt = 2'd0;
            end
        end
    end

    cav_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .space_ok (space_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = m_result.pixel;
    assign m_tlast = m_result.frame_end;

endmodule

`default_nettype wire
